>>> hdl/mhkv_pkg.sv
package mhkv_pkg;

	localparam int KEY_W    = 64;
	localparam int DATA_W   = 64;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 13;
	localparam int IDXB_W   = 4;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// word index of each register, taken from paddr[2]
	localparam logic REG_INDEX_BITS = 1'b0;

	localparam logic [IDXB_W-1:0] INDEX_BITS_RESET = 4'd10;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_FIND   = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_READ,
		S_CMP,
		S_WRITE,
		S_CLEAR,
		S_DONE
	} state_t;

endpackage

>>> hdl/masked_hash_key_value_table.sv
// channel   | handshake           | payload
// ----------+---------------------+-------------------------------------
// request   | req_valid/req_stall | operation, key, value
// response  | rsp_valid/rsp_stall | status, found_value, entry_total
// config    | apb psel/penable    | index_bits at byte address 0
//
// insert, find and delete go through these steps from accept to the next accept:
// one bucket row read, then one way a cycle through the shared key comparator,
// a row write back and a result hand-off. a clear sweeps the row memory one
// row a cycle. after reset the same sweep runs over every row with req_stall
// high; config writes are taken throughout. a held response does not block
// the next request, only the hand-off of its result.
module masked_hash_key_value_table #(
	parameter int BUCKET_BITS = 10,
	parameter int WAYS        = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [mhkv_pkg::OP_W-1:0]           operation,
	input  logic [mhkv_pkg::KEY_W-1:0]          key,
	input  logic [mhkv_pkg::DATA_W-1:0]         value,

	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [mhkv_pkg::STATUS_W-1:0]       status,
	output logic [mhkv_pkg::DATA_W-1:0]         found_value,
	output logic [mhkv_pkg::TOTAL_W-1:0]        entry_total,

	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mhkv_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [mhkv_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [mhkv_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	localparam int NROWS  = 1 << BUCKET_BITS;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CNT_W  = BUCKET_BITS + WAY_W + 1;

	typedef struct packed {
		logic [WAYS-1:0]                            vld;
		logic [WAYS-1:0][mhkv_pkg::KEY_W-1:0]       key;
		logic [WAYS-1:0][mhkv_pkg::DATA_W-1:0]      data;
		logic [WAYS-1:0][RANK_W-1:0]                rank;
	} row_t;

	typedef struct packed {
		logic req_stall;
		logic mem_we;
		logic sweep;
		logic rsp_load;
	} ctrl_t;

	mhkv_pkg::state_t state_q, state_nx;
	ctrl_t ctrl;

	logic [mhkv_pkg::IDXB_W-1:0]   index_bits_q;
	mhkv_pkg::op_t                 op_q;
	logic [mhkv_pkg::KEY_W-1:0]    key_q;
	logic [mhkv_pkg::DATA_W-1:0]   value_q;
	logic [BUCKET_BITS-1:0]        row_addr_q;
	logic [BUCKET_BITS-1:0]        clr_addr_q;
	logic [WAY_W-1:0]              way_q;
	logic                          best_vld_q;
	logic [WAY_W-1:0]              best_way_q;
	logic [RANK_W-1:0]             best_rank_q;
	logic                          free_vld_q;
	logic [WAY_W-1:0]              free_way_q;
	logic [CNT_W-1:0]              cnt_q;
	mhkv_pkg::status_t             res_status_q;
	logic [mhkv_pkg::DATA_W-1:0]   res_found_q;

	logic                          rsp_valid_q;
	logic [mhkv_pkg::STATUS_W-1:0] status_q;
	logic [mhkv_pkg::DATA_W-1:0]   found_value_q;
	logic [mhkv_pkg::TOTAL_W-1:0]  entry_total_q;

	row_t mem [NROWS];
	row_t rd_row_q;
	row_t new_row;
	row_t wr_row;
	logic [BUCKET_BITS-1:0] wr_addr;

	logic                   req_take;
	logic                   last_way;
	logic                   last_row;
	logic                   cmp_hit;
	logic [RANK_W-1:0]      cmp_rank;
	logic                   row_change;
	logic [BUCKET_BITS-1:0] bucket_mask;
	logic [BUCKET_BITS-1:0] bucket_idx;
	logic                   cfg_we;

	// config port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == mhkv_pkg::REG_INDEX_BITS);
	assign prdata = (paddr[2] == mhkv_pkg::REG_INDEX_BITS) ?
		mhkv_pkg::APB_DATA_W'(index_bits_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q <= mhkv_pkg::INDEX_BITS_RESET;
		end else if (cfg_we) begin
			index_bits_q <= pwdata[mhkv_pkg::IDXB_W-1:0];
		end
	end

	// a shift of index_bits_q at or past BUCKET_BITS leaves the full mask
	assign bucket_mask = ~({BUCKET_BITS{1'b1}} << index_bits_q);
	assign bucket_idx  = key[BUCKET_BITS-1:0] & bucket_mask;

	assign req_take = req_valid && !ctrl.req_stall;
	assign last_way = (way_q == WAY_W'(WAYS - 1));
	assign last_row = (clr_addr_q == {BUCKET_BITS{1'b1}});

	// shared compare unit, one way a cycle
	assign cmp_hit  = rd_row_q.vld[way_q] && (rd_row_q.key[way_q] == key_q);
	assign cmp_rank = rd_row_q.rank[way_q];

	assign row_change = ((op_q == mhkv_pkg::OP_INSERT) && free_vld_q) ||
		((op_q == mhkv_pkg::OP_DELETE) && best_vld_q);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			mhkv_pkg::S_INIT: begin
				if (last_row) state_nx = mhkv_pkg::S_IDLE;
			end
			mhkv_pkg::S_IDLE: begin
				if (req_valid) begin
					if (mhkv_pkg::op_t'(operation) == mhkv_pkg::OP_CLEAR)
						state_nx = mhkv_pkg::S_CLEAR;
					else
						state_nx = mhkv_pkg::S_READ;
				end
			end
			mhkv_pkg::S_READ:  state_nx = mhkv_pkg::S_CMP;
			mhkv_pkg::S_CMP: begin
				if (last_way) state_nx = mhkv_pkg::S_WRITE;
			end
			mhkv_pkg::S_WRITE: state_nx = mhkv_pkg::S_DONE;
			mhkv_pkg::S_CLEAR: begin
				if (last_row) state_nx = mhkv_pkg::S_DONE;
			end
			mhkv_pkg::S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) state_nx = mhkv_pkg::S_IDLE;
			end
			default: state_nx = mhkv_pkg::S_INIT;
		endcase
	end

	// control outputs
	always_comb begin
		ctrl = '{req_stall: 1'b1, mem_we: 1'b0, sweep: 1'b0, rsp_load: 1'b0};
		unique case (state_q)
			mhkv_pkg::S_INIT,
			mhkv_pkg::S_CLEAR: begin
				ctrl.mem_we = 1'b1;
				ctrl.sweep  = 1'b1;
			end
			mhkv_pkg::S_IDLE:  ctrl.req_stall = 1'b0;
			mhkv_pkg::S_WRITE: ctrl.mem_we = row_change;
			mhkv_pkg::S_DONE:  ctrl.rsp_load = !rsp_valid_q || !rsp_stall;
			default: ;
		endcase
	end

	assign req_stall = ctrl.req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mhkv_pkg::S_INIT;
			clr_addr_q <= '0;
			way_q      <= '0;
			best_vld_q <= 1'b0;
			free_vld_q <= 1'b0;
			cnt_q      <= '0;
		end else begin
			state_q <= state_nx;
			if (ctrl.sweep) clr_addr_q <= clr_addr_q + 1'b1;
			if (req_take) begin
				way_q      <= '0;
				best_vld_q <= 1'b0;
				free_vld_q <= 1'b0;
				clr_addr_q <= '0;
				if (mhkv_pkg::op_t'(operation) == mhkv_pkg::OP_CLEAR) cnt_q <= '0;
			end
			if (state_q == mhkv_pkg::S_CMP) begin
				way_q <= way_q + 1'b1;
				// newest match is the lowest rank among hits
				if (cmp_hit && (!best_vld_q || cmp_rank < best_rank_q))
					best_vld_q <= 1'b1;
				if (!rd_row_q.vld[way_q] && !free_vld_q)
					free_vld_q <= 1'b1;
			end
			if (state_q == mhkv_pkg::S_WRITE) begin
				if ((op_q == mhkv_pkg::OP_INSERT) && free_vld_q)
					cnt_q <= cnt_q + 1'b1;
				else if ((op_q == mhkv_pkg::OP_DELETE) && best_vld_q && (cnt_q != '0))
					cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// request payload and per-item working values
	always_ff @(posedge clk) begin
		if (req_take) begin
			op_q       <= mhkv_pkg::op_t'(operation);
			key_q      <= key;
			value_q    <= value;
			row_addr_q <= bucket_idx;
			if (mhkv_pkg::op_t'(operation) == mhkv_pkg::OP_CLEAR) begin
				res_status_q <= mhkv_pkg::STS_OK;
				res_found_q  <= '0;
			end
		end
		if (state_q == mhkv_pkg::S_CMP) begin
			if (cmp_hit && (!best_vld_q || cmp_rank < best_rank_q)) begin
				best_way_q  <= way_q;
				best_rank_q <= cmp_rank;
			end
			if (!rd_row_q.vld[way_q] && !free_vld_q)
				free_way_q <= way_q;
		end
		if (state_q == mhkv_pkg::S_WRITE) begin
			case (op_q)
				mhkv_pkg::OP_INSERT: begin
					res_found_q  <= '0;
					res_status_q <= free_vld_q ? mhkv_pkg::STS_OK : mhkv_pkg::STS_FULL;
				end
				mhkv_pkg::OP_FIND: begin
					res_found_q  <= best_vld_q ? rd_row_q.data[best_way_q] : '0;
					res_status_q <= best_vld_q ? mhkv_pkg::STS_OK : mhkv_pkg::STS_NOT_FOUND;
				end
				mhkv_pkg::OP_DELETE: begin
					res_found_q  <= '0;
					res_status_q <= best_vld_q ? mhkv_pkg::STS_OK : mhkv_pkg::STS_NOT_FOUND;
				end
				default: begin
					res_found_q  <= '0;
					res_status_q <= mhkv_pkg::STS_OK;
				end
			endcase
		end
	end

	// updated bucket row for insert and delete
	always_comb begin
		new_row = rd_row_q;
		case (op_q)
			mhkv_pkg::OP_INSERT: begin
				for (int w = 0; w < WAYS; w++) begin
					if (rd_row_q.vld[w]) new_row.rank[w] = rd_row_q.rank[w] + 1'b1;
				end
				new_row.vld[free_way_q]  = 1'b1;
				new_row.key[free_way_q]  = key_q;
				new_row.data[free_way_q] = value_q;
				new_row.rank[free_way_q] = '0;
			end
			mhkv_pkg::OP_DELETE: begin
				for (int w = 0; w < WAYS; w++) begin
					if (rd_row_q.vld[w] && (WAY_W'(w) != best_way_q) &&
						(rd_row_q.rank[w] > best_rank_q))
						new_row.rank[w] = rd_row_q.rank[w] - 1'b1;
				end
				new_row.vld[best_way_q] = 1'b0;
			end
			default: ;
		endcase
	end

	assign wr_addr = ctrl.sweep ? clr_addr_q : row_addr_q;
	assign wr_row  = ctrl.sweep ? row_t'('0) : new_row;

	// bucket row memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (ctrl.mem_we) mem[wr_addr] <= wr_row;
		rd_row_q <= mem[row_addr_q];
	end

	// response word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rsp_load) begin
			status_q      <= res_status_q;
			found_value_q <= res_found_q;
			entry_total_q <= mhkv_pkg::TOTAL_W'(cnt_q);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign found_value = found_value_q;
	assign entry_total = entry_total_q;

endmodule
